// ===== sv/bmpup_pkg.sv =====
// shared types and constants for the pixel replicate upscaler
package bmpup_pkg;

   localparam int unsigned DEF_MAX_WIDTH = 2048;
   localparam int unsigned DEF_MAX_SCALE = 100;

   localparam int unsigned SCALE_W    = 7;
   localparam int unsigned WIDTH_W    = 12;
   localparam int unsigned HEIGHT_W   = 16;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned LOAD_COL_W = 12;
   localparam int unsigned EMIT_COL_W = 11;
   localparam int unsigned PIXEL_W    = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd2;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_PULL = 1'b1;

   typedef logic [PIXEL_W-1:0] pixel_type;

   typedef struct packed {
      logic                  wr_en;
      logic [LOAD_COL_W-1:0] wr_col;
      pixel_type             wr_pixel;
      logic                  rd_en;
      logic [EMIT_COL_W-1:0] rd_col;
   } mem_cmd_type;

   typedef struct packed {
      logic [1:0] pad_after;
      logic       row_end;
      logic       image_end;
   } tag_type;

endpackage

// ===== sv/bmpup_line_buf.sv =====
// single-port-per-direction line buffer memory with registered read
module bmpup_line_buf #(
   parameter int unsigned MAX_WIDTH = bmpup_pkg::DEF_MAX_WIDTH
) (
   input  logic                  clock,
   input  bmpup_pkg::mem_cmd_type cmd,
   output bmpup_pkg::pixel_type  rd_data
);

   localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   bmpup_pkg::pixel_type mem [MAX_WIDTH];
   bmpup_pkg::pixel_type rd_data_ff;
   logic                 rd_ok_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en && (32'(cmd.wr_col) < MAX_WIDTH)) begin
         mem[AW'(cmd.wr_col)] <= cmd.wr_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[AW'(cmd.rd_col)];
         rd_ok_ff   <= (32'(cmd.rd_col) < MAX_WIDTH);
      end
   end

   assign rd_data = rd_ok_ff ? rd_data_ff : '0;

endmodule

// ===== sv/bmpup_ctrl.sv =====
// configuration registers and row/column sequencing counters
module bmpup_ctrl #(
   parameter int unsigned MAX_WIDTH = bmpup_pkg::DEF_MAX_WIDTH,
   parameter int unsigned MAX_SCALE = bmpup_pkg::DEF_MAX_SCALE
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [bmpup_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bmpup_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                  accept,
   input  logic                                  req_type,
   input  bmpup_pkg::pixel_type                  req_pixel,
   output bmpup_pkg::mem_cmd_type                mem_cmd,
   output logic                                  tag_valid,
   output bmpup_pkg::tag_type                    tag
);

   logic [bmpup_pkg::SCALE_W-1:0]    scale_ff, scale_in;
   logic [bmpup_pkg::WIDTH_W-1:0]    width_ff, width_in;
   logic [bmpup_pkg::HEIGHT_W-1:0]   height_ff, height_in;
   logic [bmpup_pkg::LOAD_COL_W-1:0] load_col_ff, load_col_in;
   logic                             row_ready_ff, row_ready_in;
   logic [bmpup_pkg::EMIT_COL_W-1:0] emit_col_ff, emit_col_in;
   logic [bmpup_pkg::SCALE_W-1:0]    across_ff, across_in;
   logic [bmpup_pkg::SCALE_W-1:0]    down_ff, down_in;
   logic [bmpup_pkg::HEIGHT_W-1:0]   src_row_ff, src_row_in;

   logic [bmpup_pkg::SCALE_W-1:0]    eff_scale;
   logic [bmpup_pkg::WIDTH_W-1:0]    eff_width;
   logic [bmpup_pkg::HEIGHT_W-1:0]   eff_height;
   logic [bmpup_pkg::LOAD_COL_W-1:0] lc_inc;
   logic [bmpup_pkg::EMIT_COL_W-1:0] ec_inc;
   logic [bmpup_pkg::SCALE_W-1:0]    ar_inc, dr_inc;
   logic [bmpup_pkg::HEIGHT_W-1:0]   sr_inc;
   logic                             image_done;
   logic                             do_load, do_pull;

   always_comb begin
      eff_scale = (32'(scale_ff) > MAX_SCALE) ? bmpup_pkg::SCALE_W'(MAX_SCALE) : scale_ff;
      if (width_ff == '0) begin
         eff_width = bmpup_pkg::WIDTH_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_width = bmpup_pkg::WIDTH_W'(MAX_WIDTH);
      end else begin
         eff_width = width_ff;
      end
      eff_height = (height_ff == '0) ? bmpup_pkg::HEIGHT_W'(1) : height_ff;
   end

   assign do_load = accept && (req_type == bmpup_pkg::REQ_LOAD) && !row_ready_ff;
   assign do_pull = accept && (req_type == bmpup_pkg::REQ_PULL) && row_ready_ff;

   assign lc_inc     = load_col_ff + 1'b1;
   assign ec_inc     = emit_col_ff + 1'b1;
   assign ar_inc     = across_ff + 1'b1;
   assign dr_inc     = down_ff + 1'b1;
   assign sr_inc     = src_row_ff + 1'b1;
   assign image_done = (sr_inc >= eff_height) || (sr_inc == '0);

   always_comb begin
      scale_in     = scale_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      load_col_in  = load_col_ff;
      row_ready_in = row_ready_ff;
      emit_col_in  = emit_col_ff;
      across_in    = across_ff;
      down_in      = down_ff;
      src_row_in   = src_row_ff;
      tag          = '0;

      if (csr_write_en) begin
         case (csr_index)
            bmpup_pkg::CSR_SCALE:      scale_in  = csr_write_data[bmpup_pkg::SCALE_W-1:0];
            bmpup_pkg::CSR_SRC_WIDTH:  width_in  = csr_write_data[bmpup_pkg::WIDTH_W-1:0];
            bmpup_pkg::CSR_SRC_HEIGHT: height_in = csr_write_data[bmpup_pkg::HEIGHT_W-1:0];
            default: ;
         endcase
      end

      if (do_load) begin
         load_col_in = lc_inc;
         if ((lc_inc >= eff_width) || (lc_inc == '0)) begin
            load_col_in = '0;
            if (eff_scale == '0) begin
               emit_col_in = '0;
               across_in   = '0;
               down_in     = '0;
               src_row_in  = image_done ? '0 : sr_inc;
            end else begin
               row_ready_in = 1'b1;
            end
         end
      end

      if (do_pull) begin
         across_in = ar_inc;
         if ((ar_inc >= eff_scale) || (ar_inc == '0)) begin
            across_in   = '0;
            emit_col_in = ec_inc;
            if ((bmpup_pkg::WIDTH_W'(ec_inc) >= eff_width) || (ec_inc == '0)) begin
               tag.row_end   = 1'b1;
               tag.pad_after = 2'(eff_width[1:0] * eff_scale[1:0]);
               emit_col_in   = '0;
               down_in       = dr_inc;
               if ((dr_inc >= eff_scale) || (dr_inc == '0)) begin
                  row_ready_in  = 1'b0;
                  load_col_in   = '0;
                  down_in       = '0;
                  src_row_in    = image_done ? '0 : sr_inc;
                  tag.image_end = image_done;
               end
            end
         end
      end
   end

   always_comb begin
      mem_cmd.wr_en    = do_load;
      mem_cmd.wr_col   = load_col_ff;
      mem_cmd.wr_pixel = req_pixel;
      mem_cmd.rd_en    = do_pull;
      mem_cmd.rd_col   = emit_col_ff;
   end

   assign tag_valid = do_pull;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= bmpup_pkg::SCALE_W'(1);
         width_ff     <= bmpup_pkg::WIDTH_W'(1);
         height_ff    <= bmpup_pkg::HEIGHT_W'(1);
         load_col_ff  <= '0;
         row_ready_ff <= 1'b0;
         emit_col_ff  <= '0;
         across_ff    <= '0;
         down_ff      <= '0;
         src_row_ff   <= '0;
      end else begin
         scale_ff     <= scale_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         load_col_ff  <= load_col_in;
         row_ready_ff <= row_ready_in;
         emit_col_ff  <= emit_col_in;
         across_ff    <= across_in;
         down_ff      <= down_in;
         src_row_ff   <= src_row_in;
      end
   end

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_cmd.wr_en && mem_cmd.rd_en))
      else $error("line buffer written and read by one transfer");

   a_pull_needs_row: assert property (@(posedge clock) disable iff (reset)
      tag_valid |-> row_ready_ff)
      else $error("pixel issued with no row stored");

endmodule

// ===== sv/bmpup_out.sv =====
// read-data stage and output register with backpressure
module bmpup_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tag_valid,
   input  bmpup_pkg::tag_type   tag,
   input  bmpup_pkg::pixel_type rd_data,
   input  logic                 rsp_stall,
   output logic                 req_stall,
   output logic                 rsp_valid,
   output bmpup_pkg::pixel_type rsp_pixel,
   output bmpup_pkg::tag_type   rsp_tag
);

   logic                 s1_valid_ff, s1_valid_in;
   bmpup_pkg::tag_type   s1_tag_ff, s1_tag_in;
   logic                 out_valid_ff, out_valid_in;
   bmpup_pkg::pixel_type out_pixel_ff, out_pixel_in;
   bmpup_pkg::tag_type   out_tag_ff, out_tag_in;
   logic                 s1_adv, s1_move;

   assign s1_adv    = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && s1_adv;
   assign req_stall = s1_valid_ff && !s1_adv;

   always_comb begin
      s1_valid_in  = tag_valid || (s1_valid_ff && !s1_adv);
      s1_tag_in    = tag_valid ? tag : s1_tag_ff;
      out_valid_in = s1_move || (out_valid_ff && rsp_stall);
      out_pixel_in = s1_move ? rd_data : out_pixel_ff;
      out_tag_in   = s1_move ? s1_tag_ff : out_tag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff    <= s1_tag_in;
      out_pixel_ff <= out_pixel_in;
      out_tag_ff   <= out_tag_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_pixel = out_pixel_ff;
   assign rsp_tag   = out_tag_ff;

endmodule

// ===== sv/bmp_pixel_replicate_upscaler_top.sv =====
// Integer nearest-neighbor upscaler for 24-bit pixels. Loads (req_type 0) fill a line buffer
// memory of MAX_WIDTH entries; once a full source row is stored, pulls (req_type 1) return
// output pixels, each source pixel repeated scale times across and each row scale times down,
// with the padding byte count (width*scale) mod 4 on the last pixel of every output row.
// One transfer is taken every cycle while req_stall is low. A pull reads the synchronous
// line buffer at the edge that takes it, loading the read stage; the output register then
// loads from the read stage once that register is empty or rsp_stall is low. Input is
// stalled only while the output register is held and the read stage behind it is full.
// Configuration is written through the csr port while no pixel is in flight.
module bmp_pixel_replicate_upscaler_top #(
   parameter int unsigned MAX_WIDTH = bmpup_pkg::DEF_MAX_WIDTH,
   parameter int unsigned MAX_SCALE = bmpup_pkg::DEF_MAX_SCALE
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [bmpup_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bmpup_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [7:0]                       req_red_in,
   input  logic [7:0]                       req_green_in,
   input  logic [7:0]                       req_blue_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_red_out,
   output logic [7:0]                       rsp_green_out,
   output logic [7:0]                       rsp_blue_out,
   output logic [1:0]                       rsp_pad_after,
   output logic                             rsp_row_end,
   output logic                             rsp_image_end
);

   logic                   accept;
   bmpup_pkg::mem_cmd_type mem_cmd;
   logic                   tag_valid;
   bmpup_pkg::tag_type     tag;
   bmpup_pkg::pixel_type   rd_data;
   bmpup_pkg::pixel_type   rsp_pixel;
   bmpup_pkg::tag_type     rsp_tag;

   assign accept = req_valid && !req_stall;

   bmpup_ctrl #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_SCALE (MAX_SCALE)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .accept         (accept),
      .req_type       (req_type),
      .req_pixel      ({req_red_in, req_green_in, req_blue_in}),
      .mem_cmd        (mem_cmd),
      .tag_valid      (tag_valid),
      .tag            (tag)
   );

   bmpup_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .cmd     (mem_cmd),
      .rd_data (rd_data)
   );

   bmpup_out u_out (
      .clock     (clock),
      .reset     (reset),
      .tag_valid (tag_valid),
      .tag       (tag),
      .rd_data   (rd_data),
      .rsp_stall (rsp_stall),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_pixel (rsp_pixel),
      .rsp_tag   (rsp_tag)
   );

   assign rsp_red_out   = rsp_pixel[23:16];
   assign rsp_green_out = rsp_pixel[15:8];
   assign rsp_blue_out  = rsp_pixel[7:0];
   assign rsp_pad_after = rsp_tag.pad_after;
   assign rsp_row_end   = rsp_tag.row_end;
   assign rsp_image_end = rsp_tag.image_end;

   a_image_end_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_image_end) |-> rsp_row_end)
      else $error("image end without row end");

   a_pad_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_pad_after != 2'd0)) |-> rsp_row_end)
      else $error("padding reported inside a row");

   a_pull_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (tag_valid && !rsp_valid) |=> ##1 rsp_valid)
      else $error("pulled pixel did not reach the output");

endmodule
